[rtl/phv2_pkg.sv]
// Package for the PROXY v2 header parser: result types, status and family
// codes, and fixed sizes of the header layout. No dependencies.
package phv2_pkg;

  localparam int unsigned CAPTURE_DEPTH = 36;
  localparam int unsigned CAP_IDX_W     = $clog2(CAPTURE_DEPTH);
  localparam int unsigned LEN_W         = 16;

  localparam logic [3:0]       VERSION_2     = 4'h2;
  localparam logic [3:0]       MAX_FAMILY    = 4'h3;
  localparam logic [3:0]       MAX_TRANSPORT = 4'h2;
  localparam logic             CMD_PROXY     = 1'b1;
  localparam logic [LEN_W-1:0] INET_MIN_LEN  = 16'd12;
  localparam logic [LEN_W-1:0] INET6_MIN_LEN = 16'd36;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_VERSION,
    ST_BAD_COMMAND,
    ST_BAD_FAMILY,
    ST_BAD_PROTOCOL
  } status_e;

  typedef enum logic [1:0] {
    FAM_UNSPEC,
    FAM_INET,
    FAM_INET6,
    FAM_UNIX
  } family_e;

  typedef logic [CAPTURE_DEPTH-1:0][7:0] cap_arr_t;

  typedef struct packed {
    logic                 en;
    logic [CAP_IDX_W-1:0] idx;
    logic [7:0]           data;
  } cap_wr_t;

  typedef struct packed {
    status_e          status;
    logic             command_proxy;
    logic [1:0]       address_family;
    logic [1:0]       transport;
    logic             addresses_valid;
    logic [63:0]      source_high;
    logic [63:0]      source_low;
    logic [63:0]      dest_high;
    logic [63:0]      dest_low;
    logic [15:0]      source_port;
    logic [15:0]      dest_port;
    logic [LEN_W-1:0] extra_bytes;
  } res_t;

endpackage

[rtl/phv2_if.sv]
// Valid/ready channel interfaces for the PROXY v2 header parser: the byte
// stream in and the parsed result out. No dependencies.
interface phv2_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface phv2_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        command_proxy;
  logic [1:0]  address_family;
  logic [1:0]  transport;
  logic        addresses_valid;
  logic [63:0] source_high;
  logic [63:0] source_low;
  logic [63:0] dest_high;
  logic [63:0] dest_low;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] extra_bytes;

  modport source (
    output valid, output status, output command_proxy, output address_family,
    output transport, output addresses_valid, output source_high, output source_low,
    output dest_high, output dest_low, output source_port, output dest_port,
    output extra_bytes, input ready
  );
  modport sink (
    input valid, input status, input command_proxy, input address_family,
    input transport, input addresses_valid, input source_high, input source_low,
    input dest_high, input dest_low, input source_port, input dest_port,
    input extra_bytes, output ready
  );
endinterface

[rtl/phv2_capture.sv]
// Store for the first extra bytes of a header, one register per byte.
// Depends on phv2_pkg for the depth and the write struct.
module phv2_capture (
  input  logic               clk_i,
  input  phv2_pkg::cap_wr_t  wr_i,
  input  logic               commit_i,
  output phv2_pkg::cap_arr_t view_o
);
  import phv2_pkg::*;

  cap_arr_t cap_q;

  // The view already holds the byte being parsed, so a result on the last
  // captured byte sees it.
  always_comb begin
    view_o = cap_q;
    if (wr_i.en) begin
      view_o[wr_i.idx] = wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i && wr_i.en) begin
      cap_q[wr_i.idx] <= wr_i.data;
    end
  end

endmodule

[rtl/phv2_parser.sv]
// Header position tracking, nibble checks and result assembly for one byte.
// Depends on phv2_pkg; the capture store is read through its view port.
module phv2_parser #(
  parameter int unsigned PREFIX_LEN = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         byte_i,
  input  logic               advance_i,
  input  phv2_pkg::cap_arr_t cap_i,
  output phv2_pkg::cap_wr_t  cap_wr_o,
  output logic               res_valid_o,
  output phv2_pkg::res_t     res_o
);
  import phv2_pkg::*;

  localparam int unsigned POS_W = $clog2(PREFIX_LEN + 4 + (1 << LEN_W));

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] p, k;
  logic             cmd_q, cmd_d;
  logic [1:0]       fam_q, fam_d;
  logic [1:0]       tr_q, tr_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [3:0]       hi, lo;
  logic             give_ok;
  logic             give_err;
  status_e          err_code;
  logic             v4_ok, v6_ok;
  res_t             ok_res;

  assign hi = byte_i[7:4];
  assign lo = byte_i[3:0];
  assign p  = pos_q - POS_W'(PREFIX_LEN);
  assign k  = p - POS_W'(4);

  always_comb begin
    pos_d    = pos_q + POS_W'(1);
    cmd_d    = cmd_q;
    fam_d    = fam_q;
    tr_d     = tr_q;
    len_d    = len_q;
    give_ok  = 1'b0;
    give_err = 1'b0;
    err_code = ST_OK;
    cap_wr_o = '{en: 1'b0, idx: k[CAP_IDX_W-1:0], data: byte_i};
    priority if (pos_q < POS_W'(PREFIX_LEN)) begin
      // Signature bytes are skipped unchecked.
    end else if (p == POS_W'(0)) begin
      if (hi != VERSION_2) begin
        give_err = 1'b1;
        err_code = ST_BAD_VERSION;
      end else if (lo[3:1] != 3'd0) begin
        give_err = 1'b1;
        err_code = ST_BAD_COMMAND;
      end else begin
        cmd_d = lo[0];
      end
    end else if (p == POS_W'(1)) begin
      if (hi > MAX_FAMILY) begin
        give_err = 1'b1;
        err_code = ST_BAD_FAMILY;
      end else if (lo > MAX_TRANSPORT) begin
        give_err = 1'b1;
        err_code = ST_BAD_PROTOCOL;
      end else begin
        fam_d = hi[1:0];
        tr_d  = lo[1:0];
      end
    end else if (p == POS_W'(2)) begin
      len_d = {byte_i, 8'h00};
    end else if (p == POS_W'(3)) begin
      len_d   = {len_q[15:8], byte_i};
      give_ok = (len_d == '0);
    end else begin
      cap_wr_o.en = (k < POS_W'(CAPTURE_DEPTH));
      give_ok     = ((k + POS_W'(1)) >= POS_W'(len_q));
    end
    if (give_ok || give_err) begin
      pos_d = '0;
    end
  end

  // Address block is reported only when the extra length covers it.
  assign v4_ok = (cmd_q == CMD_PROXY) && (fam_q == FAM_INET) && (len_d >= INET_MIN_LEN);
  assign v6_ok = (cmd_q == CMD_PROXY) && (fam_q == FAM_INET6) && (len_d >= INET6_MIN_LEN);

  always_comb begin
    ok_res                 = '0;
    ok_res.status          = ST_OK;
    ok_res.command_proxy   = cmd_q;
    ok_res.address_family  = fam_q;
    ok_res.transport       = tr_q;
    ok_res.extra_bytes     = len_d;
    ok_res.addresses_valid = v4_ok || v6_ok;
    if (v4_ok) begin
      ok_res.source_low  = {32'd0, cap_i[0], cap_i[1], cap_i[2], cap_i[3]};
      ok_res.dest_low    = {32'd0, cap_i[4], cap_i[5], cap_i[6], cap_i[7]};
      ok_res.source_port = {cap_i[8], cap_i[9]};
      ok_res.dest_port   = {cap_i[10], cap_i[11]};
    end else if (v6_ok) begin
      ok_res.source_high = {cap_i[0], cap_i[1], cap_i[2], cap_i[3],
                            cap_i[4], cap_i[5], cap_i[6], cap_i[7]};
      ok_res.source_low  = {cap_i[8], cap_i[9], cap_i[10], cap_i[11],
                            cap_i[12], cap_i[13], cap_i[14], cap_i[15]};
      ok_res.dest_high   = {cap_i[16], cap_i[17], cap_i[18], cap_i[19],
                            cap_i[20], cap_i[21], cap_i[22], cap_i[23]};
      ok_res.dest_low    = {cap_i[24], cap_i[25], cap_i[26], cap_i[27],
                            cap_i[28], cap_i[29], cap_i[30], cap_i[31]};
      ok_res.source_port = {cap_i[32], cap_i[33]};
      ok_res.dest_port   = {cap_i[34], cap_i[35]};
    end
  end

  always_comb begin
    res_valid_o = give_ok || give_err;
    if (give_err) begin
      res_o        = '0;
      res_o.status = err_code;
    end else begin
      res_o = ok_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cmd_q <= 1'b0;
      fam_q <= 2'd0;
      tr_q  <= 2'd0;
      len_q <= '0;
    end else if (advance_i) begin
      pos_q <= pos_d;
      cmd_q <= cmd_d;
      fam_q <= fam_d;
      tr_q  <= tr_d;
      len_q <= len_d;
    end
  end

endmodule

[rtl/proxy_v2_header_parser_top.sv]
// Top level of the PROXY v2 header parser: input byte register, parser,
// capture store and result register. Depends on phv2_pkg and phv2_if.
//
//   channel   dir  modport  payload
//   in_i      in   sink     data_byte (8)
//   out_o     out  source   status, header fields, addresses, ports, extra_bytes
//
// One byte is accepted every cycle unless a waiting result stalls it; the byte
// completing or failing the header passes the input and the result register.
// The input register feeds the parse logic, which writes the result register.
// Reset clears the header position, the held fields and both valid flags;
// the capture store is not reset and is only read after a header writes it.
// A stalled result holds only bytes that would produce a new result.
module proxy_v2_header_parser_top #(
  parameter int unsigned PREFIX_LEN = 12
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  phv2_in_if.sink    in_i,
  phv2_out_if.source out_o
);
  import phv2_pkg::*;

  logic       in_vq;
  logic [7:0] in_byte_q;
  logic       out_vq;
  res_t       out_q;
  logic       go;
  logic       res_valid;
  res_t       res;
  cap_wr_t    cap_wr;
  cap_arr_t   cap_view;

  assign go         = in_vq && (!out_vq || out_o.ready || !res_valid);
  assign in_i.ready = !in_vq || go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_i.ready) begin
      in_vq <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
    end
  end

  phv2_parser #(
    .PREFIX_LEN(PREFIX_LEN)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (in_byte_q),
    .advance_i  (go),
    .cap_i      (cap_view),
    .cap_wr_o   (cap_wr),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  phv2_capture u_capture (
    .clk_i   (clk_i),
    .wr_i    (cap_wr),
    .commit_i(go),
    .view_o  (cap_view)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (go && res_valid) begin
      out_vq <= 1'b1;
    end else if (out_o.ready) begin
      out_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_vq;
  assign out_o.status          = out_q.status;
  assign out_o.command_proxy   = out_q.command_proxy;
  assign out_o.address_family  = out_q.address_family;
  assign out_o.transport       = out_q.transport;
  assign out_o.addresses_valid = out_q.addresses_valid;
  assign out_o.source_high     = out_q.source_high;
  assign out_o.source_low      = out_q.source_low;
  assign out_o.dest_high       = out_q.dest_high;
  assign out_o.dest_low        = out_q.dest_low;
  assign out_o.source_port     = out_q.source_port;
  assign out_o.dest_port       = out_q.dest_port;
  assign out_o.extra_bytes     = out_q.extra_bytes;

  // A new result never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(go && res_valid && out_vq && !out_o.ready))
    else $error("result register overwritten while stalled");

  // Error results carry nothing but the status code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && out_q.status != ST_OK) |->
      (!out_q.addresses_valid && out_q.extra_bytes == '0 && !out_q.command_proxy))
    else $error("error result carries header fields");

  // Addresses come only with a proxy command on an IP family.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && out_q.addresses_valid) |->
      (out_q.command_proxy &&
       (out_q.address_family == FAM_INET || out_q.address_family == FAM_INET6)))
    else $error("addresses flagged without proxy command on an IP family");

  // IPv4 results leave the upper address words clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vq && out_q.address_family == FAM_INET) |->
      (out_q.source_high == '0 && out_q.dest_high == '0))
    else $error("IPv4 result has upper address bits set");

endmodule

[tb/sv/proxy_v2_header_parser_checker.sv]
// Scoreboard for the PROXY v2 header parser. It watches the byte and report
// channels, predicts each report from the accepted bytes and compares them.
// Depends on phv2_pkg and on the channel interfaces in phv2_if.
module proxy_v2_header_parser_checker #(
  parameter int unsigned PREFIX_LEN = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  phv2_in_if   byte_i,
  phv2_out_if  report_i,
  output int   mismatch_count_o,
  output int   pending_count_o
);
  import phv2_pkg::*;

  logic [16:0] hdr_pos;
  logic        held_cmd;
  family_e     held_fam;
  logic [1:0]  held_tp;
  logic [15:0] held_len;
  logic [7:0]  extra_store [CAPTURE_DEPTH];
  res_t        expected_reports [$];

  res_t seen_report;
  res_t due_report;
  res_t next_report;
  bit   makes_report;

  // Big-endian read of captured extra bytes.
  function automatic logic [63:0] extra_be(int unsigned start, int unsigned count);
    logic [63:0] v;
    int unsigned i;
    v = '0;
    for (i = 0; i < count; i++) begin
      v = {v[55:0], extra_store[(start + i) % CAPTURE_DEPTH]};
    end
    return v;
  endfunction

  function automatic res_t header_report();
    res_t r;
    r = '0;
    r.status         = ST_OK;
    r.command_proxy  = held_cmd;
    r.address_family = held_fam;
    r.transport      = held_tp;
    r.extra_bytes    = held_len;
    if (held_cmd == CMD_PROXY) begin
      if (held_fam == FAM_INET && held_len >= INET_MIN_LEN) begin
        r.addresses_valid = 1'b1;
        r.source_low      = extra_be(0, 4);
        r.dest_low        = extra_be(4, 4);
        r.source_port     = 16'(extra_be(8, 2));
        r.dest_port       = 16'(extra_be(10, 2));
      end else if (held_fam == FAM_INET6 && held_len >= INET6_MIN_LEN) begin
        r.addresses_valid = 1'b1;
        r.source_high     = extra_be(0, 8);
        r.source_low      = extra_be(8, 8);
        r.dest_high       = extra_be(16, 8);
        r.dest_low        = extra_be(24, 8);
        r.source_port     = 16'(extra_be(32, 2));
        r.dest_port       = 16'(extra_be(34, 2));
      end
    end
    return r;
  endfunction

  function automatic res_t error_report(status_e code);
    res_t r;
    r = '0;
    r.status = code;
    return r;
  endfunction

  // Advances the header position by one byte; any report ends the header.
  task automatic parse_byte(input logic [7:0] b, output bit produced, output res_t r);
    int unsigned p;
    int unsigned k;
    produced = 1'b0;
    r = '0;
    if (hdr_pos < PREFIX_LEN) begin
      hdr_pos = hdr_pos + 17'd1;
    end else begin
      p = hdr_pos - PREFIX_LEN;
      if (p == 0) begin
        if (b[7:4] != VERSION_2) begin
          produced = 1'b1;
          r = error_report(ST_BAD_VERSION);
        end else if (b[3:1] != 3'b000) begin
          produced = 1'b1;
          r = error_report(ST_BAD_COMMAND);
        end else begin
          held_cmd = b[0];
          hdr_pos = hdr_pos + 17'd1;
        end
      end else if (p == 1) begin
        if (b[7:4] > MAX_FAMILY) begin
          produced = 1'b1;
          r = error_report(ST_BAD_FAMILY);
        end else if (b[3:0] > MAX_TRANSPORT) begin
          produced = 1'b1;
          r = error_report(ST_BAD_PROTOCOL);
        end else begin
          held_fam = family_e'(b[5:4]);
          held_tp = b[1:0];
          hdr_pos = hdr_pos + 17'd1;
        end
      end else if (p == 2) begin
        held_len = {b, 8'h00};
        hdr_pos = hdr_pos + 17'd1;
      end else if (p == 3) begin
        held_len[7:0] = b;
        if (held_len == '0) begin
          produced = 1'b1;
          r = header_report();
        end else begin
          hdr_pos = hdr_pos + 17'd1;
        end
      end else begin
        // Bytes past the capture depth are consumed but not stored.
        k = p - 4;
        if (k < CAPTURE_DEPTH) extra_store[k] = b;
        if (k + 1 >= held_len) begin
          produced = 1'b1;
          r = header_report();
        end else begin
          hdr_pos = hdr_pos + 17'd1;
        end
      end
    end
    if (produced) hdr_pos = '0;
  endtask

  function automatic string describe(res_t r);
    return $sformatf({"status %0d cmd %0b fam %0d tp %0d addr %0b",
                      " src %h_%h:%h dst %h_%h:%h len %0d"},
                     r.status, r.command_proxy, r.address_family, r.transport,
                     r.addresses_valid, r.source_high, r.source_low, r.source_port,
                     r.dest_high, r.dest_low, r.dest_port, r.extra_bytes);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos  = '0;
      held_cmd = 1'b0;
      held_fam = FAM_UNSPEC;
      held_tp  = '0;
      held_len = '0;
      expected_reports.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      // Compare the report beat before predicting from this edge's byte beat.
      if (report_i.valid && report_i.ready) begin
        seen_report.status          = status_e'(report_i.status);
        seen_report.command_proxy   = report_i.command_proxy;
        seen_report.address_family  = report_i.address_family;
        seen_report.transport       = report_i.transport;
        seen_report.addresses_valid = report_i.addresses_valid;
        seen_report.source_high     = report_i.source_high;
        seen_report.source_low      = report_i.source_low;
        seen_report.dest_high       = report_i.dest_high;
        seen_report.dest_low        = report_i.dest_low;
        seen_report.source_port     = report_i.source_port;
        seen_report.dest_port       = report_i.dest_port;
        seen_report.extra_bytes     = report_i.extra_bytes;
        if (expected_reports.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: report with none expected: %s", $time, describe(seen_report));
        end else begin
          due_report = expected_reports.pop_front();
          if (seen_report !== due_report) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10) begin
              $display("%0t: report mismatch, expected %s", $time, describe(due_report));
              $display("%0t:                  actual   %s", $time, describe(seen_report));
            end
          end
        end
      end
      if (byte_i.valid && byte_i.ready) begin
        parse_byte(byte_i.data_byte, makes_report, next_report);
        if (makes_report) expected_reports.push_back(next_report);
      end
      pending_count_o = expected_reports.size();
    end
  end

endmodule

[tb/sv/proxy_v2_header_parser_top_tb.sv]
// Testbench top for proxy_v2_header_parser_top: feeds header byte streams with
// random idling, stalls the report side and prints the verdict.
// Depends on phv2_pkg, phv2_if, the block and proxy_v2_header_parser_checker.
module proxy_v2_header_parser_top_tb;
  import phv2_pkg::*;

  localparam int unsigned PREFIX_LEN   = 12;
  localparam int unsigned RUN_LIMIT    = 2_000_000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned TARGET_BYTES = 1100;

  localparam logic [3:0] CMD_NIB_LOCAL  = 4'd0;
  localparam logic [3:0] CMD_NIB_PROXY  = {3'b000, CMD_PROXY};
  localparam logic [3:0] FAM_NIB_UNSPEC = {2'b00, FAM_UNSPEC};
  localparam logic [3:0] FAM_NIB_INET   = {2'b00, FAM_INET};
  localparam logic [3:0] FAM_NIB_INET6  = {2'b00, FAM_INET6};
  localparam logic [3:0] FAM_NIB_UNIX   = {2'b00, FAM_UNIX};
  localparam logic [3:0] TP_UNSPEC = 4'd0;
  localparam logic [3:0] TP_STREAM = 4'd1;
  localparam logic [3:0] TP_DGRAM  = 4'd2;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;
  // How far a header goes: up to the version byte, the family byte, or whole.
  typedef enum {CUT_VERSION, CUT_FAMILY, CUT_NONE} cut_e;

  logic clk_i;
  logic rst_ni;

  phv2_in_if  byte_if ();
  phv2_out_if report_if ();

  bit          quiet;
  bit          hold_req;
  logic [7:0]  stream_q [$];
  int unsigned bytes_sent;
  int          mismatches;
  int          pending_reports;

  proxy_v2_header_parser_top #(
    .PREFIX_LEN (PREFIX_LEN)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (report_if)
  );

  proxy_v2_header_parser_checker #(
    .PREFIX_LEN (PREFIX_LEN)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .byte_i           (byte_if),
    .report_i         (report_if),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending_reports)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #(RUN_LIMIT);
    $display("proxy_v2_header_parser_top_tb NOT OK");
    $finish;
  end

  function automatic logic [7:0] ver_cmd(logic [3:0] ver, logic [3:0] cmd);
    return {ver, cmd};
  endfunction

  function automatic logic [7:0] fam_tp(logic [3:0] fam, logic [3:0] tp);
    return {fam, tp};
  endfunction

  task automatic queue_header(input logic [7:0] vc, input logic [7:0] fp,
                              input logic [15:0] len, input fill_e fill, input cut_e cut);
    int unsigned i;
    for (i = 0; i < PREFIX_LEN; i++) stream_q.push_back(8'($urandom));
    stream_q.push_back(vc);
    if (cut != CUT_VERSION) begin
      stream_q.push_back(fp);
      if (cut == CUT_NONE) begin
        stream_q.push_back(len[15:8]);
        stream_q.push_back(len[7:0]);
        for (i = 0; i < len; i++) begin
          case (fill)
            FILL_ZERO: stream_q.push_back(8'h00);
            FILL_ONES: stream_q.push_back(8'hFF);
            default:   stream_q.push_back(8'($urandom));
          endcase
        end
      end
    end
  endtask

  task automatic queue_random_good();
    logic [3:0]  cmd;
    logic [3:0]  fam;
    logic [3:0]  tp;
    logic [15:0] len;
    int unsigned sel;
    cmd = ($urandom_range(0, 4) != 0) ? CMD_NIB_PROXY : CMD_NIB_LOCAL;
    sel = $urandom_range(0, 9);
    fam = (sel < 4) ? FAM_NIB_INET : (sel < 8) ? FAM_NIB_INET6 :
          (sel == 8) ? FAM_NIB_UNSPEC : FAM_NIB_UNIX;
    tp = 4'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0:          len = '0;
      1:          len = INET_MIN_LEN;
      2:          len = INET6_MIN_LEN;
      3, 4, 5, 6: len = 16'($urandom_range(1, 40));
      7:          len = (fam == FAM_NIB_INET6) ? 16'($urandom_range(12, 35))
                                               : 16'($urandom_range(1, 11));
      8:          len = 16'($urandom_range(37, 64));
      default:    len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(65, 400))
                                                    : 16'($urandom_range(0, 16));
    endcase
    queue_header(ver_cmd(VERSION_2, cmd), fam_tp(fam, tp), len, FILL_RANDOM, CUT_NONE);
  endtask

  task automatic queue_random_bad();
    logic [3:0] ver;
    case ($urandom_range(0, 3))
      0: begin
        ver = 4'($urandom_range(0, 15));
        if (ver == VERSION_2) ver = ver + 4'd1;
        queue_header(ver_cmd(ver, 4'($urandom)), 8'h00, '0, FILL_RANDOM, CUT_VERSION);
      end
      1: queue_header(ver_cmd(VERSION_2, 4'($urandom_range(2, 15))), 8'h00, '0,
                      FILL_RANDOM, CUT_VERSION);
      2: queue_header(ver_cmd(VERSION_2, 4'($urandom_range(0, 1))),
                      fam_tp(4'($urandom_range(4, 15)), 4'($urandom)), '0,
                      FILL_RANDOM, CUT_FAMILY);
      default: queue_header(ver_cmd(VERSION_2, 4'($urandom_range(0, 1))),
                            fam_tp(4'($urandom_range(0, 3)), 4'($urandom_range(3, 15))),
                            '0, FILL_RANDOM, CUT_FAMILY);
    endcase
  endtask

  // Holds one byte on the channel until its beat; valid stays up for a
  // back-to-back successor.
  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid <= 1'b1;
    byte_if.data_byte <= value;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_stream();
    while (stream_q.size() > 0) send_byte(stream_q.pop_front());
  endtask

  initial begin : byte_source
    int unsigned pick;
    int unsigned n;
    byte_if.valid <= 1'b0;
    byte_if.data_byte <= 8'h00;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // Directed headers: well-formed families, lengths and error codes.
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET, TP_STREAM), 16'd12,
                 FILL_RANDOM, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET, TP_DGRAM), 16'd12,
                 FILL_ONES, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET, TP_UNSPEC), 16'd12,
                 FILL_ZERO, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET6, TP_STREAM), 16'd36,
                 FILL_RANDOM, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET6, TP_DGRAM), 16'd36,
                 FILL_ONES, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_LOCAL), fam_tp(FAM_NIB_UNSPEC, TP_UNSPEC), 16'd0,
                 FILL_RANDOM, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET, TP_STREAM), 16'd0,
                 FILL_RANDOM, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_LOCAL), fam_tp(FAM_NIB_INET, TP_STREAM), 16'd12,
                 FILL_RANDOM, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_UNIX, TP_STREAM), 16'd20,
                 FILL_RANDOM, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_UNSPEC, TP_DGRAM), 16'd5,
                 FILL_RANDOM, CUT_NONE);
    // Extra blocks too short to hold the addresses.
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET, TP_STREAM), 16'd11,
                 FILL_RANDOM, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET6, TP_STREAM), 16'd35,
                 FILL_RANDOM, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET6, TP_STREAM), 16'd12,
                 FILL_RANDOM, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET, TP_STREAM), 16'd1,
                 FILL_RANDOM, CUT_NONE);
    // Extra blocks longer than the capture store.
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET, TP_STREAM), 16'd40,
                 FILL_RANDOM, CUT_NONE);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET6, TP_DGRAM), 16'd100,
                 FILL_RANDOM, CUT_NONE);
    // Bad nibbles; a bad version wins over a bad command, a bad family over
    // a bad protocol.
    queue_header(ver_cmd(4'h1, CMD_NIB_PROXY), 8'h00, '0, FILL_RANDOM, CUT_VERSION);
    queue_header(ver_cmd(4'hF, CMD_NIB_PROXY), 8'h00, '0, FILL_RANDOM, CUT_VERSION);
    queue_header(ver_cmd(4'h1, 4'hF), 8'h00, '0, FILL_RANDOM, CUT_VERSION);
    queue_header(ver_cmd(VERSION_2, 4'h2), 8'h00, '0, FILL_RANDOM, CUT_VERSION);
    queue_header(ver_cmd(VERSION_2, 4'hF), 8'h00, '0, FILL_RANDOM, CUT_VERSION);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(4'h4, TP_STREAM), '0,
                 FILL_RANDOM, CUT_FAMILY);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(4'hF, TP_DGRAM), '0,
                 FILL_RANDOM, CUT_FAMILY);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(4'h4, 4'hF), '0,
                 FILL_RANDOM, CUT_FAMILY);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_PROXY), fam_tp(FAM_NIB_INET, 4'h3), '0,
                 FILL_RANDOM, CUT_FAMILY);
    queue_header(ver_cmd(VERSION_2, CMD_NIB_LOCAL), fam_tp(FAM_NIB_UNSPEC, 4'hF), '0,
                 FILL_RANDOM, CUT_FAMILY);
    send_stream();

    // Long report stall while short error headers keep coming, so the
    // block backs up onto its byte input; then drain completely.
    hold_req = 1'b1;
    quiet = 1'b1;
    repeat (12) queue_header(ver_cmd(4'h3, CMD_NIB_PROXY), 8'h00, '0, FILL_RANDOM,
                             CUT_VERSION);
    send_stream();
    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_reports == 0);
    quiet = 1'b0;

    while (bytes_sent < TARGET_BYTES) begin
      quiet = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        queue_random_good();
      end else if (pick < 88) begin
        queue_random_bad();
      end else begin
        n = $urandom_range(1, 20);
        repeat (n) stream_q.push_back(8'($urandom));
      end
      send_stream();
    end

    byte_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_reports == 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("proxy_v2_header_parser_top_tb OK");
    end else begin
      $display("proxy_v2_header_parser_top_tb NOT OK");
    end
    $finish;
  end

  initial begin : report_sink
    int unsigned stall;
    report_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        stall = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        report_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      report_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!report_if.valid) @(posedge clk_i);
    end
  end

endmodule
